>>> hw/rtl/qecs_pkg.sv
// Package for the quadrature encoder count and speed block.
// Holds the event codes, field widths and reset constants. No dependencies.
package qecs_pkg;

  localparam int unsigned ChannelsDef   = 4;
  localparam int unsigned CountW        = 32;
  localparam int unsigned SpeedW        = 16;
  localparam int unsigned PeriodW       = 16;
  localparam int unsigned ChanFieldW    = 2;
  localparam logic [PeriodW-1:0] SamplePeriodRst = 16'd100;

  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_CLR_ONE = 2'd2,
    OP_CLR_ALL = 2'd3
  } op_e;

endpackage

>>> hw/rtl/quad_encoder_count_and_speed.sv
// Quadrature encoder x1 counter with periodic speed sampling; uses qecs_pkg.
// Path: an input transaction passes the input register, then the result register.
// Throughput: 1 transaction per cycle unless the output stalls; per-channel
// count/speed regs update in stage 2; back-to-back events need no forwarding.
// Reset: async active low; counts, last-sample counts, speeds and the tick
// counter clear to zero, sample period returns to 100 ticks.
module quad_encoder_count_and_speed
  import qecs_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration: sample period in ticks
  input  logic                     cfg_wr_en_i,
  input  logic [PeriodW-1:0]       cfg_wr_data_i,
  // event channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic [ChanFieldW-1:0]    channel_i,
  input  logic                     b_level_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CountW-1:0] count_value_o,
  output logic signed [SpeedW-1:0] speed_value_o,
  output logic                     sample_taken_o
);

  // Index width into the per-channel registers.
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Channel field zero-extended wide enough to compare against CHANNELS.
  localparam int unsigned ExtW = (IdxW > ChanFieldW) ? IdxW + 1 : ChanFieldW + 1;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [PeriodW-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= SamplePeriodRst;
    end else if (cfg_wr_en_i) begin
      period_q <= cfg_wr_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. Stage 1 holds the accepted event; stage 2 is the result
  // register. The result register loads whenever it is empty or being
  // drained, and the input register refills in the same cycle it empties.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_load;
  logic in_take;

  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Input register payload (no reset needed).
  op_e                   s1_op_q;
  logic [ChanFieldW-1:0] s1_chan_q;
  logic                  s1_b_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= op_e'(operation_i);
      s1_chan_q <= channel_i;
      s1_b_q    <= b_level_i;
    end
  end

  // ---------------------------------------------------------------------
  // Channel state
  // ---------------------------------------------------------------------
  logic [CountW-1:0]  count_q   [CHANNELS];
  logic [CountW-1:0]  count_d   [CHANNELS];
  logic [CountW-1:0]  last_q    [CHANNELS];
  logic [CountW-1:0]  last_d    [CHANNELS];
  logic [SpeedW-1:0]  speed_q   [CHANNELS];
  logic [SpeedW-1:0]  speed_d   [CHANNELS];
  logic [PeriodW-1:0] elapsed_q;
  logic [PeriodW-1:0] elapsed_d;
  logic [PeriodW-1:0] elapsed_inc;
  logic               sample_now;

  // Channel numbers past the configured count are ignored for edge/clear
  // and read back as zero.
  logic [ExtW-1:0] chan_ext;
  logic            present;
  logic [IdxW-1:0] idx;

  assign chan_ext = ExtW'(s1_chan_q);
  assign present  = chan_ext < ExtW'(CHANNELS);
  assign idx      = chan_ext[IdxW-1:0];

  // Tick counter wraps at 16 bits; a period of zero samples on every tick.
  assign elapsed_inc = elapsed_q + 1'b1;
  assign sample_now  = (s1_op_q == OP_TICK) && (elapsed_inc >= period_q);

  always_comb begin
    elapsed_d = elapsed_q;
    for (int i = 0; i < CHANNELS; i++) begin
      count_d[i] = count_q[i];
      last_d[i]  = last_q[i];
      speed_d[i] = speed_q[i];
    end
    case (s1_op_q)
      OP_EDGE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (present && (idx == IdxW'(i))) begin
            count_d[i] = s1_b_q ? count_q[i] + 1'b1 : count_q[i] - 1'b1;
          end
        end
      end
      OP_TICK: begin
        elapsed_d = sample_now ? '0 : elapsed_inc;
        if (sample_now) begin
          for (int i = 0; i < CHANNELS; i++) begin
            speed_d[i] = SpeedW'(count_q[i] - last_q[i]);
            last_d[i]  = count_q[i];
          end
        end
      end
      OP_CLR_ONE: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (present && (idx == IdxW'(i))) begin
            count_d[i] = '0;
          end
        end
      end
      OP_CLR_ALL: begin
        // last-sample counts and speeds are kept: next speed shows the jump
        for (int i = 0; i < CHANNELS; i++) begin
          count_d[i] = '0;
        end
      end
      default: begin
        elapsed_d = elapsed_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_q[i] <= '0;
        last_q[i]  <= '0;
        speed_q[i] <= '0;
      end
    end else if (out_load) begin
      elapsed_q <= elapsed_d;
      for (int i = 0; i < CHANNELS; i++) begin
        count_q[i] <= count_d[i];
        last_q[i]  <= last_d[i];
        speed_q[i] <= speed_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: readback of the named channel after this event.
  // ---------------------------------------------------------------------
  logic [CountW-1:0] count_res_q;
  logic [SpeedW-1:0] speed_res_q;
  logic              sampled_res_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      count_res_q   <= present ? count_d[idx] : '0;
      speed_res_q   <= present ? speed_d[idx] : '0;
      sampled_res_q <= sample_now;
    end
  end

  assign count_value_o  = count_res_q;
  assign speed_value_o  = speed_res_q;
  assign sample_taken_o = sampled_res_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic all_zero;

  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (count_q[i] != '0) begin
        all_zero = 1'b0;
      end
    end
  end

  // A pending sample result means the tick counter was just restarted.
  a_sample_restarts_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sampled_res_q |-> elapsed_q == '0)
    else $error("sample reported but tick counter not restarted");

  // Input is only held off when both stages are occupied.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // Clear-all leaves every count at zero.
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (s1_op_q == OP_CLR_ALL) |=> all_zero)
    else $error("clear-all left a nonzero count");

  // Only a processed tick moves the tick counter.
  a_elapsed_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_load && (s1_op_q == OP_TICK)) |=> $stable(elapsed_q))
    else $error("tick counter moved without a tick");

endmodule

>>> tb/quad_encoder_count_and_speed_tb.sv
// Self-checking testbench for quad_encoder_count_and_speed.
// Depends on qecs_pkg and the block's RTL only; carries its own model of the
// counts, the sample-period logic and the speed readback.
`timescale 1ns / 1ps

module quad_encoder_count_and_speed_tb;
  import qecs_pkg::*;

  // Spare cycles waited once every expected readback has arrived, when idling.
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned TailCycles    = 8;
  // Cycles with no transaction on any port before the run is declared hung.
  localparam int unsigned WatchdogLimit = 2000;

  // One expected readback per accepted event.
  typedef struct packed {
    logic signed [CountW-1:0] count;
    logic signed [SpeedW-1:0] speed;
    logic                     sampled;
  } readback_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_wr_en_i   = 1'b0;
  logic [PeriodW-1:0]       cfg_wr_data_i = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               operation_i   = '0;
  logic [ChanFieldW-1:0]    channel_i     = '0;
  logic                     b_level_i     = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic signed [CountW-1:0] count_value_o;
  logic signed [SpeedW-1:0] speed_value_o;
  logic                     sample_taken_o;

  // Idle percentages for the event sender and the result receiver.
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;

  // Readbacks predicted but not yet seen at the output, oldest first.
  readback_t expected_readbacks[$];

  // Encoder model: per-channel counts, counts at the last sample, speeds,
  // the tick counter and the sample period register.
  logic [CountW-1:0]  mdl_count      [ChannelsDef];
  logic [CountW-1:0]  mdl_last_count [ChannelsDef];
  logic [SpeedW-1:0]  mdl_speed      [ChannelsDef];
  logic [PeriodW-1:0] mdl_elapsed;
  logic [PeriodW-1:0] mdl_period;

  quad_encoder_count_and_speed DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .channel_i      (channel_i),
    .b_level_i      (b_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .count_value_o  (count_value_o),
    .speed_value_o  (speed_value_o),
    .sample_taken_o (sample_taken_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one event to the model and returns the readback it produces.
  // All four channels exist, so every channel code is a live channel.
  function automatic readback_t advance_encoder_model(op_e op, logic [1:0] ch, logic b);
    readback_t         rb;
    logic [CountW-1:0] delta;
    rb.sampled = 1'b0;
    case (op)
      OP_EDGE: begin
        // x1 decoding: B high at the A edge counts up, B low counts down.
        if (b) mdl_count[ch] = mdl_count[ch] + 32'd1;
        else   mdl_count[ch] = mdl_count[ch] - 32'd1;
      end
      OP_TICK: begin
        // Elapsed wraps at 16 bits; a zero period samples on every tick.
        mdl_elapsed = mdl_elapsed + 16'd1;
        if (mdl_elapsed >= mdl_period) begin
          mdl_elapsed = '0;
          for (int i = 0; i < ChannelsDef; i++) begin
            delta             = mdl_count[i] - mdl_last_count[i];
            mdl_speed[i]      = delta[SpeedW-1:0];
            mdl_last_count[i] = mdl_count[i];
          end
          rb.sampled = 1'b1;
        end
      end
      // Clears touch counts only; last-sample counts and speeds remain.
      OP_CLR_ONE: mdl_count[ch] = '0;
      default: begin
        for (int i = 0; i < ChannelsDef; i++) mdl_count[i] = '0;
      end
    endcase
    rb.count = mdl_count[ch];
    rb.speed = mdl_speed[ch];
    return rb;
  endfunction

  // Sends one event transaction, with random gaps in front of it. Valid
  // stays high after acceptance so back-to-back events need no extra edge.
  task automatic send_event(input op_e op, input logic [1:0] ch, input logic b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    channel_i   <= ch;
    b_level_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_readbacks.push_back(advance_encoder_model(op, ch, b));
  endtask

  // Edges dominate, as on real pins; ticks often enough to sample regularly.
  task automatic send_random_event();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(99);
    if (pick < 60)      op = OP_EDGE;
    else if (pick < 85) op = OP_TICK;
    else if (pick < 94) op = OP_CLR_ONE;
    else                op = OP_CLR_ALL;
    send_event(op, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Stops sending and waits until every predicted readback has arrived.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_readbacks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // The period register is only written with the pipeline empty.
  task automatic write_sample_period(input logic [PeriodW-1:0] period);
    wait_results_drained();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= period;
    @(posedge clk_i);
    mdl_period   = period;
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  // Up and down edges on every channel, two non-sampling ticks, a one-channel clear.
  // Channel 1 goes below zero to exercise the signed count.
  task automatic test_event_basics();
    send_event(OP_EDGE, 2'd0, 1'b1);
    send_event(OP_EDGE, 2'd0, 1'b1);
    send_event(OP_EDGE, 2'd1, 1'b0);
    send_event(OP_EDGE, 2'd3, 1'b1);
    send_event(OP_EDGE, 2'd2, 1'b0);
    send_event(OP_TICK, 2'd0, 1'b0);
    send_event(OP_CLR_ONE, 2'd2, 1'b1);
    send_event(OP_EDGE, 2'd1, 1'b0);
    send_event(OP_TICK, 2'd1, 1'b1);
  endtask

  // The period out of reset is 100 ticks; walk the tick counter up to it.
  task automatic test_reset_period();
    while (mdl_elapsed < SamplePeriodRst - 1) send_event(OP_TICK, 2'($urandom_range(3)), 1'b0);
    send_event(OP_TICK, 2'd1, 1'b0);
  endtask

  // A sample, then clears: the next sample must show the jump back to zero
  // as a negative speed, since last-sample counts survive a clear.
  task automatic test_sample_after_clear();
    write_sample_period(16'd1);
    send_event(OP_EDGE, 2'd0, 1'b1);
    send_event(OP_EDGE, 2'd3, 1'b1);
    send_event(OP_EDGE, 2'd3, 1'b1);
    send_event(OP_TICK, 2'd3, 1'b0);
    send_event(OP_CLR_ONE, 2'd3, 1'b0);
    send_event(OP_TICK, 2'd3, 1'b1);
    send_event(OP_EDGE, 2'd2, 1'b1);
    send_event(OP_CLR_ALL, 2'd0, 1'b1);
    send_event(OP_TICK, 2'd0, 1'b0);
    send_event(OP_TICK, 2'd2, 1'b0);
  endtask

  // Period zero samples every tick, like period one; then a mid-size period.
  task automatic test_period_zero();
    write_sample_period(16'd0);
    send_event(OP_EDGE, 2'd1, 1'b1);
    send_event(OP_TICK, 2'd1, 1'b0);
    send_event(OP_TICK, 2'd1, 1'b1);
    send_event(OP_TICK, 2'd2, 1'b0);
    write_sample_period(16'd5);
    repeat (6) send_event(OP_TICK, 2'($urandom_range(3)), 1'b0);
  endtask

  // Lowering the period below the ticks already counted forces a sample
  // on the very next tick.
  task automatic test_period_lowered();
    write_sample_period(16'd1);
    send_event(OP_TICK, 2'd0, 1'b0);
    write_sample_period(16'd50);
    repeat (20) send_event(OP_TICK, 2'd0, 1'b1);
    send_event(OP_EDGE, 2'd0, 1'b1);
    write_sample_period(16'd10);
    send_event(OP_TICK, 2'd0, 1'b0);
  endtask

  // The sender holds off mid-stream until the receiver has everything.
  task automatic test_pause_until_drained();
    repeat (20) send_random_event();
    wait_results_drained();
    repeat (20) send_random_event();
  endtask

  // Random events in chunks; each chunk runs under a fresh period, mostly
  // short so samples are frequent, now and then zero or the maximum.
  task automatic test_random_events(input int unsigned num_events);
    int unsigned sel;
    for (int unsigned n = 0; n < num_events; n++) begin
      if (n % 150 == 0) begin
        sel = $urandom_range(9);
        if (sel == 0)      write_sample_period(16'd0);
        else if (sel == 1) write_sample_period(16'hFFFF);
        else if (sel == 2) write_sample_period(16'd1);
        else               write_sample_period(16'($urandom_range(12, 2)));
      end
      send_random_event();
    end
  endtask

  // Maximum period: edges and a run of ticks never reach a sample; then a
  // short period closes the interval and the speeds carry every pulse.
  // Channel 1 counts down, channel 2 up.
  task automatic test_long_period_hold();
    write_sample_period(16'd1);
    send_event(OP_TICK, 2'd0, 1'b0);
    write_sample_period(16'hFFFF);
    repeat (30) begin
      send_event(OP_EDGE, 2'd2, 1'b1);
      send_event(OP_EDGE, 2'd1, 1'b0);
    end
    repeat (100) send_event(OP_TICK, 2'($urandom_range(3)), 1'b0);
    write_sample_period(16'd1);
    send_event(OP_TICK, 2'd1, 1'b0);
    send_event(OP_EDGE, 2'd2, 1'b0);
  endtask

  // Receiver: random stall, and a field-by-field check of every result
  // transaction against the oldest prediction.
  always @(posedge clk_i) begin
    readback_t exp_rb;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_readbacks.size() == 0) begin
          $error("result transaction with no expected readback waiting");
          error_count++;
        end else begin
          exp_rb = expected_readbacks.pop_front();
          if (count_value_o !== exp_rb.count) begin
            $error("count_value: expected %0d, actual %0d", exp_rb.count, count_value_o);
            error_count++;
          end
          if (speed_value_o !== exp_rb.speed) begin
            $error("speed_value: expected %0d, actual %0d", exp_rb.speed, speed_value_o);
            error_count++;
          end
          if (sample_taken_o !== exp_rb.sampled) begin
            $error("sample_taken: expected %0b, actual %0b", exp_rb.sampled,
                   sample_taken_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: any transaction or register write restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_wr_en_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Model matches the block's reset state.
    for (int i = 0; i < ChannelsDef; i++) begin
      mdl_count[i]      = '0;
      mdl_last_count[i] = '0;
      mdl_speed[i]      = '0;
    end
    mdl_elapsed = '0;
    mdl_period  = SamplePeriodRst;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender idles a third of the time, receiver stalls heavily.
    set_idling(33, 84);
    test_event_basics();
    test_reset_period();
    test_sample_after_clear();
    test_period_zero();
    test_random_events(550);

    // Phase 2: roles swapped.
    set_idling(84, 33);
    test_period_lowered();
    test_pause_until_drained();
    test_random_events(500);

    // Phase 3: full rate both ways, including the maximum-period run.
    set_idling(0, 0);
    test_random_events(500);
    test_long_period_hold();

    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
